@@ hdl/gjdc_pkg.sv @@
// gjdc_pkg: shared types and constants for the gregorian / julian day converter
// holds the command codes, carried item layout, month offset table and reciprocals
// no dependencies
package gjdc_pkg;

  // field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned YEAR_W   = 15;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned JDN_W    = 23;
  localparam int unsigned OFFSET_W = 21;

  // packed stream widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 48;

  // largest supported day number (9999-12-31)
  localparam logic [JDN_W-1:0] JDN_MAX = 23'd5373484;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TO_NUMBER = 2'd0,
    CMD_TO_DATE   = 2'd1,
    CMD_ADD_DAYS  = 2'd2
  } cmd_e;

  // date fields that ride along the pipeline
  typedef struct packed {
    cmd_e                      cmd;
    logic signed [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0]        month;
    logic [DAY_W-1:0]          day;
  } item_t;

  // (367 * shifted month) / 12, indexed by the raw month field
  localparam logic [8:0] MONTH_OFS [16] = '{
    9'd305, 9'd336, 9'd367, 9'd30,  9'd61,  9'd91,  9'd122, 9'd152,
    9'd183, 9'd214, 9'd244, 9'd275, 9'd305, 9'd336, 9'd367, 9'd397
  };

  // exact reciprocal multipliers: ceil(2^SH / divisor), valid for the stated input width
  localparam int unsigned SH_100    = 22;   // 15-bit dividend
  localparam int unsigned SH_146097 = 43;   // 25-bit dividend
  localparam int unsigned SH_1461   = 36;   // 25-bit dividend
  localparam int unsigned SH_153    = 19;   // 11-bit dividend
  localparam int unsigned SH_5      = 11;   // 8-bit dividend

  localparam logic [15:0] RECIP_100 =
    16'(((64'd1 << SH_100) + 64'd99) / 64'd100);
  localparam logic [25:0] RECIP_146097 =
    26'(((64'd1 << SH_146097) + 64'd146096) / 64'd146097);
  localparam logic [25:0] RECIP_1461 =
    26'(((64'd1 << SH_1461) + 64'd1460) / 64'd1461);
  localparam logic [11:0] RECIP_153 =
    12'(((64'd1 << SH_153) + 64'd152) / 64'd153);
  localparam logic [8:0] RECIP_5 =
    9'(((64'd1 << SH_5) + 64'd4) / 64'd5);

endpackage

@@ hdl/gregorian_julian_day_convert.sv @@
// gregorian_julian_day_convert: pipelined proleptic gregorian date / julian day number converter
// twelve register stages with per-stage valid bits and a ripple stall chain
// depends on gjdc_pkg
//
// Takes one word per cycle while the output side is not stalled and returns one result
// word per input word, in order. A word passes through the stage 1 to stage 12 registers
// and leaves from the last once the output side takes it. The stage count is set by the
// chain of reciprocal multiplies (divide by 100 for date to number; by 146097, 1461, 153
// and 5 for number to date), each followed by its own register stage. The command travels
// in tuser: 0 turns a date into a day number (the date is echoed when the number is in
// range), 1 turns a day number into a date, 2 adds a signed offset to a date. A day number
// outside 0..5373484 is clamped to the nearer bound, range_error is set and the date of
// that bound is returned. Command 3 returns an all-zero word. A stall on the output holds
// only full stages with no empty stage after them, so bubbles still drain and input is taken.
module gregorian_julian_day_convert (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // in_year[14:0], in_month[18:15], in_day[23:19], in_day_number[46:24],
  // offset[67:47], zero[71:68]
  input  logic [71:0] s_axis_tdata_i,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_year[14:0], out_month[18:15], out_day[23:19], out_day_number[46:24], zero[47]
  output logic [47:0] m_axis_tdata_o,
  // range_error[0]
  output logic        m_axis_tuser_o
);

  localparam int unsigned NUM_STAGES = 12;

  // ---------------------------------------------------------------------------
  // stall chain: a stage loads when it is empty or the one after it moves
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES:0]   adv;

  always_comb begin
    adv[NUM_STAGES] = m_axis_tready_i;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = v_q[NUM_STAGES-1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input unpacking
  logic signed [14:0] in_year;
  logic [3:0]         in_month;
  logic [4:0]         in_day;
  logic [22:0]        in_day_number;
  logic signed [20:0] in_offset;

  assign in_year       = s_axis_tdata_i[14:0];
  assign in_month      = s_axis_tdata_i[18:15];
  assign in_day        = s_axis_tdata_i[23:19];
  assign in_day_number = s_axis_tdata_i[46:24];
  assign in_offset     = s_axis_tdata_i[67:47];

  // carried fields
  gjdc_pkg::item_t     item_q   [NUM_STAGES-1];
  logic [22:0]         jin_q    [4];
  logic signed [20:0]  off_q    [4];
  logic [22:0]         oj_q     [7];
  logic                err_q    [7];

  // ---------------------------------------------------------------------------
  // stage 1: year terms before scaling
  logic               early_month;
  logic signed [15:0] year_ext;
  logic signed [15:0] t1_d;
  logic signed [15:0] u_d;
  logic signed [15:0] s1_t1_q;
  logic               s1_u_neg_q;
  logic [14:0]        s1_u_mag_q;

  always_comb begin
    early_month = in_month < 4'd3;
    year_ext    = 16'(in_year);
    t1_d        = year_ext + (early_month ? 16'sd4799 : 16'sd4800);
    u_d         = year_ext + (early_month ? 16'sd4899 : 16'sd4900);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_t1_q    <= t1_d;
      s1_u_neg_q <= u_d[15];
      s1_u_mag_q <= u_d[15] ? 15'(-u_d) : 15'(u_d);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: 1461 * year term, century count by reciprocal multiply
  logic signed [25:0] p_d;
  logic [30:0]        cent_prod;
  logic signed [25:0] s2_p_q;
  logic               s2_u_neg_q;
  logic [8:0]         s2_cent_q;

  always_comb begin
    p_d       = 26'(s1_t1_q) * 26'sd1461;
    cent_prod = 31'(s1_u_mag_q) * 31'(gjdc_pkg::RECIP_100);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_p_q     <= p_d;
      s2_u_neg_q <= s1_u_neg_q;
      s2_cent_q  <= cent_prod[30:gjdc_pkg::SH_100];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: truncating quarter of both terms
  logic signed [25:0] p_adj;
  logic signed [25:0] p_quarter;
  logic [9:0]         cent3;
  logic signed [23:0] s3_a_q;
  logic               s3_u_neg_q;
  logic [7:0]         s3_c_mag_q;

  always_comb begin
    p_adj     = s2_p_q + (s2_p_q[25] ? 26'sd3 : 26'sd0);
    p_quarter = p_adj >>> 2;
    cent3     = 10'(s2_cent_q) * 10'd3;
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_a_q     <= 24'(p_quarter);
      s3_u_neg_q <= s2_u_neg_q;
      s3_c_mag_q <= 8'(cent3 >> 2);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: day number of the input date
  logic [24:0]        c_term;
  logic [24:0]        jdn0_d;
  logic signed [24:0] s4_jdn0_q;

  always_comb begin
    c_term = s3_u_neg_q ? 25'(s3_c_mag_q) : -25'(s3_c_mag_q);
    jdn0_d = 25'(s3_a_q) + 25'(gjdc_pkg::MONTH_OFS[item_q[2].month]) + c_term
           + 25'(item_q[2].day) - 25'd32075;
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_jdn0_q <= $signed(jdn0_d);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: command select, offset add and clamp
  logic signed [24:0] jsum;
  logic [22:0]        oj_d;
  logic               err_d;

  always_comb begin
    jsum  = s4_jdn0_q;
    oj_d  = '0;
    err_d = 1'b0;
    unique case (item_q[3].cmd)
      gjdc_pkg::CMD_TO_NUMBER: jsum = s4_jdn0_q;
      gjdc_pkg::CMD_TO_DATE:   jsum = $signed(25'(jin_q[3]));
      gjdc_pkg::CMD_ADD_DAYS:  jsum = s4_jdn0_q + 25'(off_q[3]);
      default:                 jsum = '0;
    endcase
    priority if (jsum < 0) begin
      oj_d  = '0;
      err_d = 1'b1;
    end else if (jsum > $signed(25'(gjdc_pkg::JDN_MAX))) begin
      oj_d  = gjdc_pkg::JDN_MAX;
      err_d = 1'b1;
    end else begin
      oj_d  = 23'(jsum);
      err_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: 400-year cycle count by reciprocal multiply
  logic [24:0] cyc_num;
  logic [50:0] cyc_prod;
  logic [7:0]  s6_q1_q;

  always_comb begin
    cyc_num  = 25'({oj_q[0], 2'b00}) + 25'd274277;
    cyc_prod = 51'(cyc_num) * 51'(gjdc_pkg::RECIP_146097);
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s6_q1_q <= cyc_prod[gjdc_pkg::SH_146097 +: 8];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: shifted day count f and e = 4f + 3
  logic [9:0]  q1x3;
  logic [22:0] f_d;
  logic [24:0] s7_e_q;

  always_comb begin
    q1x3 = 10'(s6_q1_q) * 10'd3;
    f_d  = oj_q[1] + 23'd1363 + 23'(q1x3 >> 2);
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s7_e_q <= {f_d, 2'b11};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: e / 1461 by reciprocal multiply
  logic [50:0] yr_prod;
  logic [13:0] s8_qe_q;
  logic [24:0] s8_e_q;

  assign yr_prod = 51'(s7_e_q) * 51'(gjdc_pkg::RECIP_1461);

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      s8_qe_q <= yr_prod[gjdc_pkg::SH_1461 +: 14];
      s8_e_q  <= s7_e_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 9: back-multiply for the remainder
  logic [13:0] s9_qe_q;
  logic [24:0] s9_e_q;
  logic [24:0] s9_qe1461_q;

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      s9_qe_q     <= s8_qe_q;
      s9_e_q      <= s8_e_q;
      s9_qe1461_q <= 25'(s8_qe_q) * 25'd1461;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 10: day of year, then h / 153 by reciprocal multiply
  logic [24:0] re_full;
  logic [8:0]  g;
  logic [10:0] h_d;
  logic [22:0] h_prod;
  logic [10:0] s10_h_q;
  logic [3:0]  s10_hq_q;
  logic [13:0] s10_qe_q;

  always_comb begin
    re_full = s9_e_q - s9_qe1461_q;
    g       = re_full[10:2];
    h_d     = 11'(g) * 11'd5 + 11'd2;
    h_prod  = 23'(h_d) * 23'(gjdc_pkg::RECIP_153);
  end

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      s10_h_q  <= h_d;
      s10_hq_q <= h_prod[gjdc_pkg::SH_153 +: 4];
      s10_qe_q <= s9_qe_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 11: month, year and the remainder for the day
  logic [10:0]        hr_full;
  logic [3:0]         mon_d;
  logic signed [14:0] yr_d;
  logic [7:0]         s11_hr_q;
  logic [3:0]         s11_mon_q;
  logic signed [14:0] s11_yr_q;

  always_comb begin
    hr_full = s10_h_q - 11'(s10_hq_q) * 11'd153;
    mon_d   = (s10_hq_q >= 4'd10) ? s10_hq_q - 4'd9 : s10_hq_q + 4'd3;
    yr_d    = $signed(15'(s10_qe_q)) - 15'sd4716 + ((mon_d <= 4'd2) ? 15'sd1 : 15'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      s11_hr_q  <= hr_full[7:0];
      s11_mon_q <= mon_d;
      s11_yr_q  <= yr_d;
    end
  end

  // carried fields: loaded at their entry stage, then shifted along
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      item_q[0] <= '{cmd:   gjdc_pkg::cmd_e'(s_axis_tuser_i),
                     year:  in_year,
                     month: in_month,
                     day:   in_day};
      jin_q[0]  <= in_day_number;
      off_q[0]  <= in_offset;
    end
    if (adv[4]) begin
      oj_q[0]  <= oj_d;
      err_q[0] <= err_d;
    end
    for (int k = 1; k < NUM_STAGES - 1; k++) begin
      if (adv[k]) begin
        item_q[k] <= item_q[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (adv[k]) begin
        jin_q[k] <= jin_q[k-1];
        off_q[k] <= off_q[k-1];
      end
    end
    for (int k = 1; k < 7; k++) begin
      if (adv[k+4]) begin
        oj_q[k]  <= oj_q[k-1];
        err_q[k] <= err_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 12: day of month and output word
  logic [16:0]        day_prod;
  logic [4:0]         dd;
  logic signed [14:0] o_year_d;
  logic [3:0]         o_month_d;
  logic [4:0]         o_day_d;
  logic [22:0]        o_jdn_d;
  logic               o_err_d;

  logic signed [14:0] o_year_q;
  logic [3:0]         o_month_q;
  logic [4:0]         o_day_q;
  logic [22:0]        o_jdn_q;
  logic               o_err_q;
  gjdc_pkg::cmd_e     o_cmd_q;

  always_comb begin
    day_prod  = 17'(s11_hr_q) * 17'(gjdc_pkg::RECIP_5);
    dd        = 5'(day_prod >> gjdc_pkg::SH_5) + 5'd1;
    o_year_d  = s11_yr_q;
    o_month_d = s11_mon_q;
    o_day_d   = dd;
    o_jdn_d   = oj_q[6];
    o_err_d   = err_q[6];
    unique case (item_q[10].cmd)
      gjdc_pkg::CMD_TO_NUMBER: begin
        // in range: echo the date as given
        if (!err_q[6]) begin
          o_year_d  = item_q[10].year;
          o_month_d = item_q[10].month;
          o_day_d   = item_q[10].day;
        end
      end
      gjdc_pkg::CMD_TO_DATE,
      gjdc_pkg::CMD_ADD_DAYS: begin
        o_year_d = s11_yr_q;
      end
      default: begin
        o_year_d  = '0;
        o_month_d = '0;
        o_day_d   = '0;
        o_jdn_d   = '0;
        o_err_d   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[11]) begin
      o_year_q  <= o_year_d;
      o_month_q <= o_month_d;
      o_day_q   <= o_day_d;
      o_jdn_q   <= o_jdn_d;
      o_err_q   <= o_err_d;
      o_cmd_q   <= item_q[10].cmd;
    end
  end

  assign m_axis_tdata_o = {1'b0, o_jdn_q, o_day_q, o_month_q, o_year_q};
  assign m_axis_tuser_o = o_err_q;

`ifndef NO_ASSERTIONS
  // input is refused only when every stage holds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // a flagged result sits on one of the bounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (o_jdn_q == '0 || o_jdn_q == gjdc_pkg::JDN_MAX))
    else $error("range error without a clamped day number");

  // day number never leaves the supported range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (o_jdn_q <= gjdc_pkg::JDN_MAX))
    else $error("day number above range");

  // a computed date is a real month and day
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (o_cmd_q == gjdc_pkg::CMD_TO_DATE ||
                         o_cmd_q == gjdc_pkg::CMD_ADD_DAYS ||
                         (o_cmd_q == gjdc_pkg::CMD_TO_NUMBER && o_err_q))) |->
      (o_month_q >= 4'd1 && o_month_q <= 4'd12 && o_day_q >= 5'd1))
    else $error("computed date out of calendar range");

  // the unused command gives an all-zero word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && o_cmd_q != gjdc_pkg::CMD_TO_NUMBER &&
     o_cmd_q != gjdc_pkg::CMD_TO_DATE && o_cmd_q != gjdc_pkg::CMD_ADD_DAYS) |->
      (m_axis_tdata_o == '0 && !m_axis_tuser_o))
    else $error("unused command gave a nonzero word");
`endif

endmodule
